[sv/bmt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Breakpoint match table package
// Shared types and codes for the breakpoint table, its scan and its store.
// ----------------------------------------------------------------------------
package bmt_pkg;

	localparam int SLOT_COUNT_DEF = 8;
	localparam int ADDR_W         = 32;

	localparam logic OP_TOGGLE = 1'b0;
	localparam logic OP_CHECK  = 1'b1;

	localparam logic [2:0] CODE_CHECK    = 3'd0;
	localparam logic [2:0] CODE_ENABLED  = 3'd1;
	localparam logic [2:0] CODE_DISABLED = 3'd2;
	localparam logic [2:0] CODE_CLAIMED  = 3'd3;
	localparam logic [2:0] CODE_FULL     = 3'd4;

	typedef struct packed {
		logic              opcode;
		logic [ADDR_W-1:0] address;
	} bmt_in_t;

	typedef struct packed {
		logic       pause;
		logic       hit;
		logic [2:0] slot;
		logic [2:0] result_code;
	} bmt_out_t;

	// comparator verdict on the slot under scan
	typedef struct packed {
		logic addr_eq;
		logic hit;
		logic slot_free;
	} bmt_cmp_t;

	// table update issued at the end of a toggle
	typedef struct packed {
		logic flip;
		logic claim;
	} bmt_wr_t;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} bmt_state_t;

endpackage

[sv/bmt_slot_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Breakpoint slot store
// Slot address memory with registered read, enable flops and written marks.
// ----------------------------------------------------------------------------
module bmt_slot_store #(
	parameter int SLOT_COUNT = bmt_pkg::SLOT_COUNT_DEF,
	parameter int IDX_W      = 3
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      rd_en,
	input  logic [IDX_W-1:0]          rd_idx,
	output logic [bmt_pkg::ADDR_W-1:0] rd_data,
	input  logic [IDX_W-1:0]          en_idx,
	output logic                      en_bit,
	input  bmt_pkg::bmt_wr_t          wr_cmd,
	input  logic [IDX_W-1:0]          wr_idx,
	input  logic [bmt_pkg::ADDR_W-1:0] wr_addr
);

	logic [bmt_pkg::ADDR_W-1:0] mem [SLOT_COUNT];
	logic [SLOT_COUNT-1:0]      enabled_q;
	logic [SLOT_COUNT-1:0]      written_q;
	logic [bmt_pkg::ADDR_W-1:0] data_s1;
	logic                       written_s1;

	always_ff @(posedge clk) begin
		if (wr_cmd.claim) begin
			mem[wr_idx] <= wr_addr;
		end
		if (rd_en) begin
			data_s1 <= mem[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q  <= '0;
			written_q  <= '0;
			written_s1 <= 1'b0;
		end else begin
			if (rd_en) begin
				written_s1 <= written_q[rd_idx];
			end
			if (wr_cmd.claim) begin
				enabled_q[wr_idx] <= 1'b1;
				written_q[wr_idx] <= 1'b1;
			end else if (wr_cmd.flip) begin
				enabled_q[wr_idx] <= ~enabled_q[wr_idx];
			end
		end
	end

	// a slot never claimed reads as address zero; the memory itself has no reset
	assign rd_data = written_s1 ? data_s1 : '0;
	assign en_bit  = enabled_q[en_idx];

endmodule

[sv/bmt_cmp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Breakpoint comparator
// Shared address compare applied to one slot per cycle during the scan.
// ----------------------------------------------------------------------------
module bmt_cmp (
	input  logic [bmt_pkg::ADDR_W-1:0] key,
	input  logic [bmt_pkg::ADDR_W-1:0] slot_addr,
	input  logic                       slot_en,
	output bmt_pkg::bmt_cmp_t          verdict
);

	logic eq;

	assign eq                = (slot_addr == key);
	assign verdict.addr_eq   = eq;
	assign verdict.hit       = eq & slot_en;
	assign verdict.slot_free = ~slot_en;

endmodule

[sv/bmt_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Breakpoint scan sequencer
// Walks the slots one per cycle, decides the item and updates the table.
// ----------------------------------------------------------------------------
module bmt_seq #(
	parameter int SLOT_COUNT = bmt_pkg::SLOT_COUNT_DEF,
	parameter int IDX_W      = 3
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  bmt_pkg::bmt_in_t           cmd,
	output logic                       done,
	output bmt_pkg::bmt_out_t          result,
	output logic                       rd_en,
	output logic [IDX_W-1:0]           rd_idx,
	output logic [IDX_W-1:0]           cmp_idx,
	output logic [bmt_pkg::ADDR_W-1:0] key,
	input  bmt_pkg::bmt_cmp_t          verdict,
	output bmt_pkg::bmt_wr_t           wr_cmd,
	output logic [IDX_W-1:0]           wr_idx
);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

	bmt_pkg::bmt_state_t state_q, state_d;

	logic                       op_q;
	logic [bmt_pkg::ADDR_W-1:0] key_q;
	logic [IDX_W-1:0]           rd_idx_q;
	logic                       issue_done_q;
	logic                       valid_s1;
	logic [IDX_W-1:0]           idx_s1;
	logic                       free_found_q;
	logic [IDX_W-1:0]           free_idx_q;
	logic                       active_valid_q;
	logic [IDX_W-1:0]           active_slot_q;
	logic                       done_q;
	bmt_pkg::bmt_out_t          result_q;

	logic                       scanning;
	logic                       last_s1;
	logic                       finish;
	logic                       claim_ok;
	logic [IDX_W-1:0]           claim_idx;
	logic                       repeat_hit;
	bmt_pkg::bmt_out_t          res_d;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bmt_pkg::ST_IDLE: begin
				if (start) state_d = bmt_pkg::ST_SCAN;
			end
			bmt_pkg::ST_SCAN: begin
				if (finish) state_d = bmt_pkg::ST_IDLE;
			end
			default: state_d = bmt_pkg::ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		busy     = 1'b0;
		scanning = 1'b0;
		case (state_q)
			bmt_pkg::ST_IDLE: begin
				busy = 1'b0;
			end
			bmt_pkg::ST_SCAN: begin
				busy     = 1'b1;
				scanning = 1'b1;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

	assign last_s1    = (idx_s1 == LAST_IDX);
	assign claim_ok   = free_found_q | verdict.slot_free;
	assign claim_idx  = free_found_q ? free_idx_q : idx_s1;
	assign repeat_hit = active_valid_q && (active_slot_q == idx_s1);

	// decision on the slot under compare
	always_comb begin
		finish = 1'b0;
		wr_cmd = '0;
		wr_idx = idx_s1;
		res_d  = '0;
		if (scanning && valid_s1) begin
			if (op_q == bmt_pkg::OP_CHECK) begin
				if (verdict.hit) begin
					finish      = 1'b1;
					res_d.hit   = 1'b1;
					res_d.pause = ~repeat_hit;
					res_d.slot  = 3'(idx_s1);
				end else if (last_s1) begin
					finish = 1'b1;
				end
				res_d.result_code = bmt_pkg::CODE_CHECK;
			end else begin
				if (verdict.addr_eq) begin
					finish      = 1'b1;
					wr_cmd.flip = 1'b1;
					res_d.slot  = 3'(idx_s1);
					res_d.result_code = verdict.slot_free ? bmt_pkg::CODE_ENABLED
					                                      : bmt_pkg::CODE_DISABLED;
				end else if (last_s1) begin
					finish = 1'b1;
					if (claim_ok) begin
						wr_cmd.claim      = 1'b1;
						wr_idx            = claim_idx;
						res_d.slot        = 3'(claim_idx);
						res_d.result_code = bmt_pkg::CODE_CLAIMED;
					end else begin
						res_d.result_code = bmt_pkg::CODE_FULL;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == bmt_pkg::ST_IDLE && start) begin
			op_q  <= cmd.opcode;
			key_q <= cmd.address;
		end
		idx_s1 <= rd_idx_q;
		if (finish) begin
			result_q <= res_d;
		end
		if (valid_s1 && verdict.slot_free && !free_found_q) begin
			free_idx_q <= idx_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= bmt_pkg::ST_IDLE;
			rd_idx_q       <= '0;
			issue_done_q   <= 1'b0;
			valid_s1       <= 1'b0;
			free_found_q   <= 1'b0;
			active_valid_q <= 1'b0;
			active_slot_q  <= '0;
			done_q         <= 1'b0;
		end else begin
			state_q  <= state_d;
			done_q   <= finish;
			valid_s1 <= scanning && !issue_done_q && !finish;
			if (state_q == bmt_pkg::ST_IDLE) begin
				rd_idx_q     <= '0;
				issue_done_q <= 1'b0;
				free_found_q <= 1'b0;
			end else begin
				if (!issue_done_q) begin
					if (rd_idx_q == LAST_IDX) issue_done_q <= 1'b1;
					else rd_idx_q <= rd_idx_q + IDX_W'(1);
				end
				if (valid_s1 && verdict.slot_free) free_found_q <= 1'b1;
			end
			// only check hits move the active mark
			if (finish && op_q == bmt_pkg::OP_CHECK && verdict.hit) begin
				active_valid_q <= ~repeat_hit;
				active_slot_q  <= idx_s1;
			end
		end
	end

	assign rd_en   = scanning && !issue_done_q;
	assign rd_idx  = rd_idx_q;
	assign cmp_idx = idx_s1;
	assign key     = key_q;
	assign done    = done_q;
	assign result  = result_q;

endmodule

[sv/breakpoint_match_table_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Breakpoint match table
// Toggle and check of breakpoint addresses against a table of slots.
// ----------------------------------------------------------------------------
// An item (toggle or check) is taken when start is high and busy is low. The
// slots are read one per cycle through the single read port of the address
// memory and tested by one shared comparator, so an item keeps busy high
// until its scan ends: a check stops at the first enabled match, a toggle
// at the first address match, and a check that misses, a toggle that claims a
// slot or a toggle that finds the table full walks every slot. The result
// appears with done for exactly one cycle, the cycle in which busy has dropped
// again; it is not held, so the receiver must take it then. Reset leaves every
// slot disabled at address zero.
module breakpoint_match_table_unit #(
	parameter int SLOT_COUNT = bmt_pkg::SLOT_COUNT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  bmt_pkg::bmt_in_t  cmd,
	output logic              done,
	output bmt_pkg::bmt_out_t result
);

	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	logic                       rd_en;
	logic [IDX_W-1:0]           rd_idx;
	logic [IDX_W-1:0]           cmp_idx;
	logic [bmt_pkg::ADDR_W-1:0] key;
	logic [bmt_pkg::ADDR_W-1:0] slot_addr;
	logic                       slot_en;
	bmt_pkg::bmt_cmp_t          verdict;
	bmt_pkg::bmt_wr_t           wr_cmd;
	logic [IDX_W-1:0]           wr_idx;

	bmt_slot_store #(
		.SLOT_COUNT(SLOT_COUNT),
		.IDX_W     (IDX_W)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (rd_en),
		.rd_idx (rd_idx),
		.rd_data(slot_addr),
		.en_idx (cmp_idx),
		.en_bit (slot_en),
		.wr_cmd (wr_cmd),
		.wr_idx (wr_idx),
		.wr_addr(key)
	);

	bmt_cmp u_cmp (
		.key      (key),
		.slot_addr(slot_addr),
		.slot_en  (slot_en),
		.verdict  (verdict)
	);

	bmt_seq #(
		.SLOT_COUNT(SLOT_COUNT),
		.IDX_W     (IDX_W)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result),
		.rd_en  (rd_en),
		.rd_idx (rd_idx),
		.cmp_idx(cmp_idx),
		.key    (key),
		.verdict(verdict),
		.wr_cmd (wr_cmd),
		.wr_idx (wr_idx)
	);

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Breakpoint match table testbench
// Sends toggle and check items to the table, predicts every outcome from a
// model of the slots and the active mark, and compares each result as done
// pulses. A directed part covers claims, flips, a full table and the
// active mark. A random part follows, built from a small pool of addresses
// with some noise mixed in.
// ----------------------------------------------------------------------------
module tb;

	localparam int SLOTS      = bmt_pkg::SLOT_COUNT_DEF;
	localparam int IDLE_LIMIT = 1000;
	localparam int POOL_N     = 12;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	bmt_pkg::bmt_in_t  cmd;
	logic              done;
	bmt_pkg::bmt_out_t result;

	// model of the table
	logic                       bp_en[SLOTS];
	logic [bmt_pkg::ADDR_W-1:0] bp_addr[SLOTS];
	logic                       halt_armed;
	int                         halt_slot;

	bmt_pkg::bmt_out_t          outcome_q[$];
	int                         fail_count = 0;
	int                         idle_cycles = 0;
	bit                         gaps_on;
	logic [bmt_pkg::ADDR_W-1:0] addr_pool[POOL_N];

	breakpoint_match_table_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bmt_pkg::bmt_out_t predict_outcome(input bmt_pkg::bmt_in_t it);
		bmt_pkg::bmt_out_t o;
		int idx;
		int i;
		o = '0;
		idx = -1;
		if (it.opcode == bmt_pkg::OP_TOGGLE) begin
			for (i = 0; i < SLOTS; i++)
				if (idx < 0 && bp_addr[i] == it.address)
					idx = i;
			if (idx >= 0) begin
				bp_en[idx] = !bp_en[idx];
				o.slot = 3'(idx);
				o.result_code = bp_en[idx] ? bmt_pkg::CODE_ENABLED
				                           : bmt_pkg::CODE_DISABLED;
			end else begin
				for (i = 0; i < SLOTS; i++)
					if (idx < 0 && !bp_en[i])
						idx = i;
				if (idx >= 0) begin
					bp_en[idx] = 1'b1;
					bp_addr[idx] = it.address;
					o.slot = 3'(idx);
					o.result_code = bmt_pkg::CODE_CLAIMED;
				end else begin
					o.result_code = bmt_pkg::CODE_FULL;
				end
			end
		end else begin
			o.result_code = bmt_pkg::CODE_CHECK;
			for (i = 0; i < SLOTS; i++)
				if (idx < 0 && bp_en[i] && bp_addr[i] == it.address)
					idx = i;
			if (idx >= 0) begin
				o.hit = 1'b1;
				o.slot = 3'(idx);
				// same slot hit straight again: no pause, mark cleared
				if (halt_armed && halt_slot == idx) begin
					halt_armed = 1'b0;
				end else begin
					halt_armed = 1'b1;
					halt_slot = idx;
					o.pause = 1'b1;
				end
			end
		end
		return o;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!gaps_on || r < 50)
			return 0;
		if (r < 92)
			return $urandom_range(1, 9);
		return $urandom_range(15, 60);
	endfunction

	task automatic send_item(input logic op, input logic [bmt_pkg::ADDR_W-1:0] addr);
		bmt_pkg::bmt_in_t it;
		int gap;
		it.opcode = op;
		it.address = addr;
		start <= 1'b1;
		cmd <= it;
		do @(posedge clk); while (busy !== 1'b0);
		outcome_q.push_back(predict_outcome(it));
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (outcome_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic report_fail(input string what, input bmt_pkg::bmt_out_t exp_o,
			input bmt_pkg::bmt_out_t got_o);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t: %s: expected pause=%0b hit=%0b slot=%0d code=%0d,",
				$realtime, what, exp_o.pause, exp_o.hit, exp_o.slot, exp_o.result_code,
				" got pause=%0b hit=%0b slot=%0d code=%0d",
				got_o.pause, got_o.hit, got_o.slot, got_o.result_code);
	endtask

	// result checker
	always @(posedge clk) begin
		bmt_pkg::bmt_out_t exp_o;
		if (arst_n && done === 1'b1) begin
			if (outcome_q.size() == 0) begin
				report_fail("result with none expected", '0, result);
			end else begin
				exp_o = outcome_q.pop_front();
				if (result.pause !== exp_o.pause || result.hit !== exp_o.hit ||
						result.slot !== exp_o.slot ||
						result.result_code !== exp_o.result_code)
					report_fail("result mismatch", exp_o, result);
			end
		end
	end

	// watchdog on cycles with no item taken and no result
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// every slot sits at address zero after reset
	task automatic test_zero_address();
		send_item(bmt_pkg::OP_TOGGLE, 32'h0000_0000);
		send_item(bmt_pkg::OP_CHECK,  32'h0000_0000);
		send_item(bmt_pkg::OP_CHECK,  32'h0000_0000);
		send_item(bmt_pkg::OP_CHECK,  32'h0000_0000);
		send_item(bmt_pkg::OP_TOGGLE, 32'h0000_0000);
		send_item(bmt_pkg::OP_CHECK,  32'h0000_0000);
	endtask

	task automatic test_fill_and_full();
		send_item(bmt_pkg::OP_TOGGLE, 32'hFFFF_FFFF);
		send_item(bmt_pkg::OP_TOGGLE, 32'h8000_0000);
		send_item(bmt_pkg::OP_TOGGLE, 32'h0000_0001);
		send_item(bmt_pkg::OP_TOGGLE, 32'h7FFF_FFFF);
		send_item(bmt_pkg::OP_TOGGLE, 32'hAAAA_AAAA);
		send_item(bmt_pkg::OP_TOGGLE, 32'h5555_5555);
		send_item(bmt_pkg::OP_TOGGLE, 32'h1234_5678);
		// last free slot still holds zero, so this flips it on
		send_item(bmt_pkg::OP_TOGGLE, 32'h0000_0000);
		send_item(bmt_pkg::OP_TOGGLE, 32'hDEAD_BEEF);
		send_item(bmt_pkg::OP_CHECK,  32'h7FFF_FFFF);
		send_item(bmt_pkg::OP_TOGGLE, 32'h0000_0001);
		send_item(bmt_pkg::OP_TOGGLE, 32'hDEAD_BEEF);
		send_item(bmt_pkg::OP_CHECK,  32'hDEAD_BEEF);
		send_item(bmt_pkg::OP_CHECK,  32'h0000_0001);
		wait_drained();
	endtask

	task automatic test_active_mark();
		send_item(bmt_pkg::OP_CHECK,  32'hFFFF_FFFF);
		send_item(bmt_pkg::OP_TOGGLE, 32'h1234_5678);
		send_item(bmt_pkg::OP_CHECK,  32'hFFFF_FFFF);
		send_item(bmt_pkg::OP_CHECK,  32'h8000_0000);
		send_item(bmt_pkg::OP_CHECK,  32'hFFFF_FFFF);
		send_item(bmt_pkg::OP_CHECK,  32'hFFFF_FFFF);
	endtask

	task automatic test_random_traffic(input int n_items);
		int sent;
		int r;
		logic [bmt_pkg::ADDR_W-1:0] last_pc;
		logic [bmt_pkg::ADDR_W-1:0] noise;
		sent = 0;
		last_pc = addr_pool[0];
		while (sent < n_items) begin
			r = $urandom_range(0, 99);
			if (r < 40) begin
				send_item(bmt_pkg::OP_TOGGLE, addr_pool[$urandom_range(0, POOL_N - 1)]);
				sent++;
			end else if (r < 85) begin
				// repeated checks drive the active mark through its cases
				if ($urandom_range(0, 99) >= 35)
					last_pc = addr_pool[$urandom_range(0, POOL_N - 1)];
				send_item(bmt_pkg::OP_CHECK, last_pc);
				sent++;
			end else if (r < 95) begin
				send_item(bmt_pkg::OP_CHECK, $urandom);
				sent++;
			end else begin
				// claim and release at once so noise never pins a slot
				noise = $urandom;
				send_item(bmt_pkg::OP_TOGGLE, noise);
				send_item(bmt_pkg::OP_TOGGLE, noise);
				sent += 2;
			end
		end
	endtask

	initial begin
		int i;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		gaps_on = 1'b1;
		halt_armed = 1'b0;
		halt_slot = 0;
		for (i = 0; i < SLOTS; i++) begin
			bp_en[i] = 1'b0;
			bp_addr[i] = '0;
		end
		addr_pool[0] = 32'hFFFF_FFFF;
		addr_pool[1] = 32'h8000_0000;
		addr_pool[2] = 32'h0000_0001;
		addr_pool[3] = 32'h7FFF_FFFF;
		addr_pool[4] = 32'hAAAA_AAAA;
		addr_pool[5] = 32'h5555_5555;
		addr_pool[6] = 32'h1234_5678;
		addr_pool[7] = 32'h0000_0000;
		addr_pool[8] = 32'hDEAD_BEEF;
		for (i = 9; i < POOL_N; i++)
			addr_pool[i] = $urandom;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_zero_address();
		test_fill_and_full();
		test_active_mark();
		test_random_traffic(150);
		gaps_on = 1'b0;
		test_random_traffic(100);
		wait_drained();
		gaps_on = 1'b1;
		test_random_traffic(180);

		wait_drained();
		repeat (SLOTS + 4) @(posedge clk);
		if (fail_count == 0 && outcome_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
